>>> rtl/core/bcc_pkg.sv
// Shared types and constants for the button click classifier.
// No dependencies; used by bcc_key and button_click_classifier_unit.
package bcc_pkg;

    // Field widths
    localparam int unsigned STAMP_W   = 32;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned IN_TDATA_W  = 40;  // 34 bits of fields, padded to bytes
    localparam int unsigned OUT_TDATA_W = 8;   // 4 bits of fields, padded to bytes

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_DEBOUNCE     = 2'd0;
    localparam logic [1:0] REG_LONG_PRESS   = 2'd1;
    localparam logic [1:0] REG_DOUBLE_CLICK = 2'd2;

    // Register reset values
    localparam logic [CFG_W-1:0] DEB_TIME_RST   = 16'd20;
    localparam logic [CFG_W-1:0] LONG_TIME_RST  = 16'd1000;
    localparam logic [CFG_W-1:0] DBL_WINDOW_RST = 16'd400;

    // Per-button phase, one-hot
    typedef enum logic [3:0] {
        PH_IDLE     = 4'b0001,
        PH_DEB_DOWN = 4'b0010,
        PH_PRESSED  = 4'b0100,
        PH_LONG     = 4'b1000
    } phase_t;

    // Event codes as carried on the result stream
    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SHORT  = 2'd1,
        EV_LONG   = 2'd2,
        EV_DOUBLE = 2'd3
    } key_evt_t;

    // Timing configuration handed to each button machine
    typedef struct packed {
        logic [CFG_W-1:0] deb_time;
        logic [CFG_W-1:0] long_time;
        logic [CFG_W-1:0] dbl_window;
    } cfg_t;

endpackage

>>> rtl/core/bcc_key.sv
// Debounce / short / long / double-click state machine for one button.
// Depends on bcc_pkg.
module bcc_key
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,     // consume one scan
    input  logic [bcc_pkg::STAMP_W-1:0] now_ms,
    input  logic                        down,     // button pressed in this scan
    input  bcc_pkg::cfg_t               cfg,
    output bcc_pkg::key_evt_t           evt,      // event for this scan (valid with step)
    output bcc_pkg::phase_t             phase
);

    bcc_pkg::phase_t             phase_reg, phase_next;
    logic [bcc_pkg::STAMP_W-1:0] press_stamp_reg, press_stamp_next;
    logic [bcc_pkg::STAMP_W-1:0] release_stamp_reg, release_stamp_next;
    logic [bcc_pkg::STAMP_W-1:0] hold;
    logic [bcc_pkg::STAMP_W-1:0] since_rel;
    logic [bcc_pkg::STAMP_W-1:0] deb_lim, long_lim, dbl_lim;

    // wrapping differences
    assign hold      = now_ms - press_stamp_reg;
    assign since_rel = now_ms - release_stamp_reg;
    assign deb_lim   = {{(bcc_pkg::STAMP_W-bcc_pkg::CFG_W){1'b0}}, cfg.deb_time};
    assign long_lim  = {{(bcc_pkg::STAMP_W-bcc_pkg::CFG_W){1'b0}}, cfg.long_time};
    assign dbl_lim   = {{(bcc_pkg::STAMP_W-bcc_pkg::CFG_W){1'b0}}, cfg.dbl_window};

    always_comb
    begin
        phase_next         = phase_reg;
        press_stamp_next   = press_stamp_reg;
        release_stamp_next = release_stamp_reg;
        evt                = bcc_pkg::EV_NONE;
        case (phase_reg)
            bcc_pkg::PH_IDLE:
            begin
                if (down)
                begin
                    phase_next       = bcc_pkg::PH_DEB_DOWN;
                    press_stamp_next = now_ms;
                end
            end
            bcc_pkg::PH_DEB_DOWN:
            begin
                if (!down)
                    phase_next = bcc_pkg::PH_IDLE;
                else if (hold >= deb_lim)
                    phase_next = bcc_pkg::PH_PRESSED;
            end
            bcc_pkg::PH_PRESSED:
            begin
                if (down)
                begin
                    if (hold >= long_lim)
                    begin
                        phase_next = bcc_pkg::PH_LONG;
                        evt        = bcc_pkg::EV_LONG;
                    end
                end
                else
                begin
                    // out-of-range holds give no event
                    if (hold < long_lim && hold >= deb_lim)
                    begin
                        if (since_rel <= dbl_lim)
                        begin
                            evt                = bcc_pkg::EV_DOUBLE;
                            release_stamp_next = '0;
                        end
                        else
                        begin
                            evt                = bcc_pkg::EV_SHORT;
                            release_stamp_next = now_ms;
                        end
                    end
                    phase_next = bcc_pkg::PH_IDLE;
                end
            end
            bcc_pkg::PH_LONG:
            begin
                if (!down)
                begin
                    phase_next         = bcc_pkg::PH_IDLE;
                    release_stamp_next = now_ms;
                end
            end
            default:
            begin
                phase_next = bcc_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= bcc_pkg::PH_IDLE;
            press_stamp_reg   <= '0;
            release_stamp_reg <= '0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            press_stamp_reg   <= press_stamp_next;
            release_stamp_reg <= release_stamp_next;
        end
    end

    assign phase = phase_reg;

endmodule

>>> rtl/core/button_click_classifier_unit.sv
// Top level of the two-button click classifier: stream ports, APB registers.
// Depends on bcc_pkg and bcc_key.
//
// Each input item is one scan: a 32-bit millisecond timestamp and the raw
// active-low levels of two buttons. Every scan yields exactly one result item
// with an event code per button (none, short, long, double). The block takes
// one item per clock while m_tready is high; an accepted item waits in the input
// register and moves to the result register once that register is empty or its
// result is taken by m_tready. The per-button next-state logic in bcc_key (two
// 32-bit wrapping subtracts and three compares) lies between those two registers.
// A result waiting on m_tready does not stop the next item from entering an
// empty input register. Timestamps wrap modulo 2^32. The three timing registers
// (debounce, long press, double-click window, in ms) sit at byte addresses 0x0,
// 0x4, 0x8 and should only be written while the block is idle.
module button_click_classifier_unit
(
    input  logic                           clk,
    input  logic                           rst_n,
    // scan input
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bcc_pkg::IN_TDATA_W-1:0] s_tdata,   // [31:0] now_ms, [32] key1_level,
                                                      // [33] key2_level, [39:34] zero
    // result output
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bcc_pkg::OUT_TDATA_W-1:0] m_tdata,  // [1:0] key1_event, [3:2] key2_event,
                                                      // [7:4] zero
    // APB configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bcc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [bcc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [bcc_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    // ---------------- configuration registers ----------------
    bcc_pkg::cfg_t cfg_reg;
    logic          cfg_wr;
    logic [1:0]    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.deb_time   <= bcc_pkg::DEB_TIME_RST;
            cfg_reg.long_time  <= bcc_pkg::LONG_TIME_RST;
            cfg_reg.dbl_window <= bcc_pkg::DBL_WINDOW_RST;
        end
        else if (cfg_wr)
        begin
            // only the low 16 bits count; unknown indexes are dropped
            case (cfg_idx)
                bcc_pkg::REG_DEBOUNCE:     cfg_reg.deb_time   <= pwdata[15:0];
                bcc_pkg::REG_LONG_PRESS:   cfg_reg.long_time  <= pwdata[15:0];
                bcc_pkg::REG_DOUBLE_CLICK: cfg_reg.dbl_window <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            bcc_pkg::REG_DEBOUNCE:     prdata = {16'b0, cfg_reg.deb_time};
            bcc_pkg::REG_LONG_PRESS:   prdata = {16'b0, cfg_reg.long_time};
            bcc_pkg::REG_DOUBLE_CLICK: prdata = {16'b0, cfg_reg.dbl_window};
            default:                   prdata = '0;
        endcase
    end

    // ---------------- input register ----------------
    logic                        in_valid_reg;
    logic [bcc_pkg::STAMP_W-1:0] now_reg;
    logic                        key1_level_reg;
    logic                        key2_level_reg;
    logic                        advance;   // input item moves to the result register
    logic                        out_valid_reg;

    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            now_reg        <= s_tdata[31:0];
            key1_level_reg <= s_tdata[32];
            key2_level_reg <= s_tdata[33];
        end
    end

    // ---------------- per-button machines ----------------
    bcc_pkg::key_evt_t key1_evt, key2_evt;
    bcc_pkg::phase_t   key1_phase, key2_phase;

    bcc_key u_key1
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .now_ms (now_reg),
        .down   (~key1_level_reg),
        .cfg    (cfg_reg),
        .evt    (key1_evt),
        .phase  (key1_phase)
    );

    bcc_key u_key2
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .now_ms (now_reg),
        .down   (~key2_level_reg),
        .cfg    (cfg_reg),
        .evt    (key2_evt),
        .phase  (key2_phase)
    );

    // ---------------- result register ----------------
    logic [1:0] key1_event_reg, key2_event_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            key1_event_reg <= key1_evt;
            key2_event_reg <= key2_evt;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, key2_event_reg, key1_event_reg};

    // ---------------- assertions ----------------
    // an empty input register never refuses an item
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("s_tready low with empty input register");

    // every item that leaves the input register shows up as a result
    a_advance_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("advanced item missing at output");

    // a long-press event always leaves button one in the long phase
    a_long_phase1: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && key1_evt == bcc_pkg::EV_LONG) |=> key1_phase == bcc_pkg::PH_LONG)
        else $error("button one long event without long phase");

    a_long_phase2: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && key2_evt == bcc_pkg::EV_LONG) |=> key2_phase == bcc_pkg::PH_LONG)
        else $error("button two long event without long phase");

endmodule
